// ----- design/modbus_write_transaction_controller_top_defines.svh -----
// ----------------------------------------------------------------------------
// modbus write controller assertion macros
// property helpers shared by the controller rtl, empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef MODBUS_WRITE_TRANSACTION_CONTROLLER_TOP_DEFINES_SVH
`define MODBUS_WRITE_TRANSACTION_CONTROLLER_TOP_DEFINES_SVH

`ifndef SYNTH
// antecedent at one edge implies consequent at the next edge
`define MBWTC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbwtc next-cycle check failed");
// condition must never hold at a clock edge
`define MBWTC_ASSERT_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("mbwtc forbidden condition seen");
`else
`define MBWTC_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`define MBWTC_ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

// ----- design/mbwtc_pkg.sv -----
// ----------------------------------------------------------------------------
// mbwtc_pkg
// types, codes and frame helpers for the modbus write transaction controller
// ----------------------------------------------------------------------------
package mbwtc_pkg;

    // input opcodes
    localparam logic [1:0] OP_TICK       = 2'd0;
    localparam logic [1:0] OP_REQUEST    = 2'd1;
    localparam logic [1:0] OP_TX_DONE    = 2'd2;
    localparam logic [1:0] OP_REPLY_BYTE = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_TX     = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // transaction status codes
    localparam logic [1:0] ST_ACK        = 2'd0;
    localparam logic [1:0] ST_NO_REPLY   = 2'd1;
    localparam logic [1:0] ST_REPLY_ERR  = 2'd2;
    localparam logic [1:0] ST_SEND_FAIL  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_ACK_TIMEOUT    = 2'd1;
    localparam logic [1:0] CFG_SEND_TIMEOUT   = 2'd2;
    localparam logic [1:0] CFG_BAD_LIMIT      = 2'd3;

    // configuration reset values
    localparam logic [7:0]  RST_DEVICE_ADDRESS = 8'd1;
    localparam logic [15:0] RST_ACK_TIMEOUT    = 16'd100;
    localparam logic [7:0]  RST_SEND_TIMEOUT   = 8'd255;
    localparam logic [3:0]  RST_BAD_LIMIT      = 4'd3;

    // commands: gears are 0..6
    localparam logic [3:0] CMD_RUN  = 4'd7;
    localparam logic [3:0] CMD_STOP = 4'd8;

    // frame constants
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [7:0]  FUNC_WRITE_REG  = 8'h06;
    localparam logic [7:0]  REG_SPEED       = 8'h1D;
    localparam logic [7:0]  REG_MODE        = 8'h27;
    localparam logic [7:0]  REG_CTRL        = 8'h2D;
    localparam logic [15:0] VAL_RUN_CTRL    = 16'h0012;
    localparam logic [15:0] VAL_RUN_MODE    = 16'h0002;
    localparam logic [15:0] VAL_STOP_MODE   = 16'h0100;
    localparam logic [15:0] VAL_STOP_CTRL   = 16'h0011;

    // gear speeds, two's complement
    localparam logic [15:0] SPEED_GEAR1 = 16'(-200);
    localparam logic [15:0] SPEED_GEAR2 = 16'(-500);
    localparam logic [15:0] SPEED_GEAR3 = 16'(-1000);
    localparam logic [15:0] SPEED_GEAR4 = 16'(-1500);
    localparam logic [15:0] SPEED_GEAR5 = 16'(-2000);
    localparam logic [15:0] SPEED_GEAR6 = 16'(-2500);
    localparam logic [15:0] SPEED_GEAR7 = 16'(-3000);

    // protocol phase
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SEND,
        PH_WAIT
    } phase_t;

    // controller sequencing state
    typedef enum logic [1:0] {
        CS_IDLE,
        CS_RESULT,
        CS_FRAME
    } ctrl_state_t;

    // input item
    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] command;
        logic [7:0] reply_byte;
        logic       reply_last;
    } req_t;

    // result item
    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] tx_byte;
        logic       frame_end;
        logic [1:0] status;
        logic       busy_res;
        logic       run_last;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic load_res;
        logic load_byte;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic start;
        logic last_byte;
    } dp_sts_t;

    // one byte through the reflected crc-16
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'd0, data};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // target register of frame one or two of a command
    function automatic logic [7:0] frame_reg(input logic [3:0] cmd, input logic second);
        logic [7:0] r;
        if (cmd == CMD_RUN) begin
            r = second ? REG_MODE : REG_CTRL;
        end else if (cmd == CMD_STOP) begin
            r = second ? REG_CTRL : REG_MODE;
        end else begin
            r = REG_SPEED;
        end
        return r;
    endfunction

    // value written by frame one or two of a command
    function automatic logic [15:0] frame_val(input logic [3:0] cmd, input logic second);
        logic [15:0] v;
        case (cmd)
            4'd0:     v = SPEED_GEAR1;
            4'd1:     v = SPEED_GEAR2;
            4'd2:     v = SPEED_GEAR3;
            4'd3:     v = SPEED_GEAR4;
            4'd4:     v = SPEED_GEAR5;
            4'd5:     v = SPEED_GEAR6;
            4'd6:     v = SPEED_GEAR7;
            CMD_RUN:  v = second ? VAL_RUN_MODE : VAL_RUN_CTRL;
            CMD_STOP: v = second ? VAL_STOP_CTRL : VAL_STOP_MODE;
            default:  v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- design/mbwtc_datapath.sv -----
// ----------------------------------------------------------------------------
// mbwtc_datapath
// protocol state, reply crc check, frame byte generator and result register
// ----------------------------------------------------------------------------
module mbwtc_datapath
    import mbwtc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  req_t        req,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  dp_cmd_t     cmd,
    output dp_sts_t     sts,
    output rsp_t        rsp
);

    // configuration registers
    logic [7:0]  device_address_reg;
    logic [15:0] ack_timeout_reg;
    logic [7:0]  send_timeout_reg;
    logic [3:0]  bad_limit_reg;

    // protocol state
    phase_t      phase_reg, phase_next;
    logic [3:0]  active_command_reg, active_command_next;
    logic [15:0] wait_counter_reg, wait_counter_next;
    logic [3:0]  bad_count_reg, bad_count_next;
    logic [15:0] reply_crc_reg, reply_crc_next;
    logic [15:0] reply_tail_reg, reply_tail_next;
    logic [7:0]  reply_count_reg, reply_count_next;

    // pending single result
    logic [1:0]  res_kind_reg, res_status_reg;
    logic        res_busy_reg;

    // frame generator
    logic [3:0]  byte_idx_reg;
    logic [15:0] tx_crc_reg;
    rsp_t        rsp_reg;

    // decision terms
    logic        start, has_status, clear_reply, reply_good;
    logic [1:0]  status_code;
    logic [15:0] wc_inc, wc_limit, crc_fed, tail_shift, crc_got;
    logic [7:0]  count_inc;
    logic [3:0]  bad_inc;

    // frame terms
    logic [2:0]  pos;
    logic        second, two_frames, last_byte;
    logic [7:0]  freg, byte_val;
    logic [15:0] fval, crc_seed;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= RST_DEVICE_ADDRESS;
            ack_timeout_reg    <= RST_ACK_TIMEOUT;
            send_timeout_reg   <= RST_SEND_TIMEOUT;
            bad_limit_reg      <= RST_BAD_LIMIT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_DEVICE_ADDRESS: device_address_reg <= cfg_data[7:0];
                CFG_ACK_TIMEOUT:    ack_timeout_reg    <= cfg_data;
                CFG_SEND_TIMEOUT:   send_timeout_reg   <= cfg_data[7:0];
                CFG_BAD_LIMIT:      bad_limit_reg      <= cfg_data[3:0];
                default:            bad_limit_reg      <= bad_limit_reg;
            endcase
        end
    end

    // per-item protocol decision
    always_comb
    begin
        phase_next          = phase_reg;
        active_command_next = active_command_reg;
        wait_counter_next   = wait_counter_reg;
        bad_count_next      = bad_count_reg;
        reply_crc_next      = reply_crc_reg;
        reply_tail_next     = reply_tail_reg;
        reply_count_next    = reply_count_reg;
        start               = 1'b0;
        has_status          = 1'b0;
        clear_reply         = 1'b0;
        status_code         = ST_ACK;

        wc_inc     = (wait_counter_reg == 16'hFFFF) ? wait_counter_reg
                                                    : wait_counter_reg + 16'd1;
        wc_limit   = (phase_reg == PH_SEND) ? {8'd0, send_timeout_reg} : ack_timeout_reg;
        crc_fed    = (reply_count_reg >= 8'd2) ? crc_feed(reply_crc_reg, reply_tail_reg[15:8])
                                               : reply_crc_reg;
        tail_shift = {reply_tail_reg[7:0], req.reply_byte};
        count_inc  = (reply_count_reg == 8'hFF) ? reply_count_reg : reply_count_reg + 8'd1;
        crc_got    = {tail_shift[7:0], tail_shift[15:8]};
        bad_inc    = (bad_count_reg == 4'hF) ? bad_count_reg : bad_count_reg + 4'd1;
        reply_good = (count_inc >= 8'd3) && (crc_got == crc_fed);

        case (req.opcode)
            OP_REQUEST:
            begin
                if (phase_reg == PH_IDLE && req.command <= CMD_STOP)
                begin
                    active_command_next = req.command;
                    bad_count_next      = 4'd0;
                    start               = 1'b1;
                end
            end
            OP_TX_DONE:
            begin
                if (phase_reg == PH_SEND)
                begin
                    phase_next        = PH_WAIT;
                    wait_counter_next = 16'd0;
                    clear_reply       = 1'b1;
                end
            end
            OP_TICK:
            begin
                if (phase_reg == PH_SEND || phase_reg == PH_WAIT)
                begin
                    wait_counter_next = wc_inc;
                    if (wc_inc >= wc_limit)
                    begin
                        phase_next        = PH_IDLE;
                        wait_counter_next = 16'd0;
                        has_status        = 1'b1;
                        status_code       = (phase_reg == PH_SEND) ? ST_SEND_FAIL : ST_NO_REPLY;
                    end
                end
            end
            default:
            begin
                // reply byte
                if (phase_reg == PH_WAIT)
                begin
                    reply_crc_next   = crc_fed;
                    reply_tail_next  = tail_shift;
                    reply_count_next = count_inc;
                    if (req.reply_last)
                    begin
                        clear_reply = 1'b1;
                        if (reply_good)
                        begin
                            phase_next        = PH_IDLE;
                            wait_counter_next = 16'd0;
                            bad_count_next    = 4'd0;
                            has_status        = 1'b1;
                            status_code       = ST_ACK;
                        end
                        else if (bad_inc >= bad_limit_reg)
                        begin
                            phase_next        = PH_IDLE;
                            wait_counter_next = 16'd0;
                            bad_count_next    = 4'd0;
                            has_status        = 1'b1;
                            status_code       = ST_REPLY_ERR;
                        end
                        else
                        begin
                            bad_count_next = bad_inc;
                            start          = 1'b1;
                        end
                    end
                end
            end
        endcase

        // a new or repeated send arms the send timer
        if (start)
        begin
            phase_next        = PH_SEND;
            wait_counter_next = 16'd0;
            clear_reply       = 1'b1;
        end

        if (clear_reply)
        begin
            reply_crc_next   = CRC_INIT;
            reply_tail_next  = 16'd0;
            reply_count_next = 8'd0;
        end
    end

    // protocol state update on an accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            active_command_reg <= 4'd0;
            wait_counter_reg   <= 16'd0;
            bad_count_reg      <= 4'd0;
            reply_crc_reg      <= CRC_INIT;
            reply_tail_reg     <= 16'd0;
            reply_count_reg    <= 8'd0;
        end
        else if (cmd.accept)
        begin
            phase_reg          <= phase_next;
            active_command_reg <= active_command_next;
            wait_counter_reg   <= wait_counter_next;
            bad_count_reg      <= bad_count_next;
            reply_crc_reg      <= reply_crc_next;
            reply_tail_reg     <= reply_tail_next;
            reply_count_reg    <= reply_count_next;
        end
    end

    // frame byte selection
    always_comb
    begin
        pos        = byte_idx_reg[2:0];
        second     = byte_idx_reg[3];
        two_frames = (active_command_reg >= CMD_RUN);
        freg       = frame_reg(active_command_reg, second);
        fval       = frame_val(active_command_reg, second);
        case (pos)
            3'd0:    byte_val = device_address_reg;
            3'd1:    byte_val = FUNC_WRITE_REG;
            3'd2:    byte_val = 8'd0;
            3'd3:    byte_val = freg;
            3'd4:    byte_val = fval[15:8];
            3'd5:    byte_val = fval[7:0];
            3'd6:    byte_val = tx_crc_reg[7:0];
            default: byte_val = tx_crc_reg[15:8];
        endcase
        crc_seed  = (pos == 3'd0) ? CRC_INIT : tx_crc_reg;
        last_byte = (pos == 3'd7) && (second || !two_frames);
    end

    // pending result, frame counter, transmit crc and result register
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            res_kind_reg   <= has_status ? KIND_STATUS : KIND_NONE;
            res_status_reg <= has_status ? status_code : ST_ACK;
            res_busy_reg   <= !has_status && (phase_next != PH_IDLE);
            byte_idx_reg   <= 4'd0;
        end
        if (cmd.load_byte)
        begin
            byte_idx_reg <= byte_idx_reg + 4'd1;
            if (pos < 3'd6)
            begin
                tx_crc_reg <= crc_feed(crc_seed, byte_val);
            end
            rsp_reg <= '{out_kind: KIND_TX, tx_byte: byte_val, frame_end: (pos == 3'd7),
                         status: ST_ACK, busy_res: 1'b1, run_last: last_byte};
        end
        else if (cmd.load_res)
        begin
            rsp_reg <= '{out_kind: res_kind_reg, tx_byte: 8'd0, frame_end: 1'b0,
                         status: res_status_reg, busy_res: res_busy_reg, run_last: 1'b1};
        end
    end

    assign sts.start     = start;
    assign sts.last_byte = last_byte;
    assign rsp           = rsp_reg;

endmodule

// ----- design/mbwtc_ctrl.sv -----
// ----------------------------------------------------------------------------
// mbwtc_ctrl
// sequences accepted beats into one no-event or status beat or a run of frame bytes
// ----------------------------------------------------------------------------
`include "modbus_write_transaction_controller_top_defines.svh"

module mbwtc_ctrl
    import mbwtc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_stall,
    output logic    rsp_valid,
    input  logic    rsp_stall,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;
    logic        accept;

    // handshake terms
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != CS_IDLE);
    assign accept    = req_valid && !req_stall;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.accept    = accept;
        unique case (state_reg)
            CS_IDLE:
            begin
                if (accept)
                begin
                    state_next = sts.start ? CS_FRAME : CS_RESULT;
                end
            end
            CS_RESULT:
            begin
                if (out_free)
                begin
                    cmd.load_res = 1'b1;
                    state_next   = CS_IDLE;
                end
            end
            CS_FRAME:
            begin
                if (out_free)
                begin
                    cmd.load_byte = 1'b1;
                    if (sts.last_byte)
                    begin
                        state_next = CS_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase

        if (cmd.load_res || cmd.load_byte)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && rsp_stall;
        end
    end

    assign rsp_valid = out_valid_reg;

    // checks
    `MBWTC_ASSERT_NEVER(a_single_load, clk, rst_n, cmd.load_res && cmd.load_byte)
    `MBWTC_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, state_reg != CS_IDLE)
    `MBWTC_ASSERT_NEXT(a_frame_done, clk, rst_n, cmd.load_byte && sts.last_byte, state_reg == CS_IDLE)
    `MBWTC_ASSERT_NEXT(a_load_valid, clk, rst_n, cmd.load_res || cmd.load_byte, out_valid_reg)

endmodule

// ----- design/modbus_write_transaction_controller_top.sv -----
// ----------------------------------------------------------------------------
// modbus_write_transaction_controller_top
// modbus rtu master issuing write-single-register frames to one slave
// ----------------------------------------------------------------------------
// usage
//   req channel (req_valid / req_stall / req): ticks, command requests,
//   transmit-done events and reply bytes, one per beat.
//   rsp channel (rsp_valid / rsp_stall / rsp): result beats; each accepted
//   req beat yields one no-event or status beat, or a run of 8 or 16 frame
//   bytes, and run_last marks the final beat of that run.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register writes,
//   always ready; the user must write only while no request is in flight, not enforced.
// timing
//   a beat without frame bytes sets the pending result register, which is
//   then loaded into the output register; a beat that starts a send
//   delivers one frame byte per cycle while rsp_stall is low.
//   the result sequencer handles one req beat at a time; req_stall stays
//   high until the last result of the current beat is in the output register.
// reset
//   clears the protocol phase and counters and restores register defaults.
// back pressure
//   while rsp_stall is high the output register holds its beat and frame
//   generation pauses at the current byte.
// ----------------------------------------------------------------------------
module modbus_write_transaction_controller_top
    import mbwtc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // config writes complete in one beat
    assign cfg_ready = 1'b1;

    // sequencer
    mbwtc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // protocol datapath
    mbwtc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp       (rsp)
    );

endmodule
